/* design/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg: shared types and constants of the motor duty shaper
// Configuration record, register indexes, reset values and the shaped
// result record passed from the shaping logic to the result register.
// ----------------------------------------------------------------------------
package mds_pkg;

    // field widths
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned SLEW_W  = 11;
    localparam int unsigned SPEED_W = 11;
    localparam int unsigned CMD_W   = 16;

    // apb geometry
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // register reset values
    localparam logic [DUTY_W-1:0] MAX_DUTY_RST  = 10'd1000;
    localparam logic [DUTY_W-1:0] DEAD_ZONE_RST = 10'd0;
    localparam logic [DUTY_W-1:0] MIN_DUTY_RST  = 10'd0;
    localparam logic [SLEW_W-1:0] SLEW_STEP_RST = 11'd2047;

    // register index within the map, address is 4 * index
    typedef enum logic [1:0] {
        REG_MAX_DUTY  = 2'd0,
        REG_DEAD_ZONE = 2'd1,
        REG_MIN_DUTY  = 2'd2,
        REG_SLEW_STEP = 2'd3
    } t_reg_idx;

    // live configuration
    typedef struct packed {
        logic [DUTY_W-1:0] max_duty;
        logic [DUTY_W-1:0] dead_zone;
        logic [DUTY_W-1:0] min_duty;
        logic [SLEW_W-1:0] slew_step;
    } t_cfg;

    // one shaped result
    typedef struct packed {
        logic                      phase_write;
        logic [DUTY_W-1:0]         phase_duty;
        logic [DUTY_W-1:0]         enable_duty;
        logic signed [SPEED_W-1:0] shaped_speed;
    } t_shaped;

endpackage

/* design/mds_apb_regs.sv */
// ----------------------------------------------------------------------------
// mds_apb_regs: configuration registers behind an apb slave
// Four registers at byte addresses 0, 4, 8 and 12, zero wait states,
// read back of the stored values.
// ----------------------------------------------------------------------------
module mds_apb_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mds_pkg::ADDR_W-1:0]   paddr,
    input  logic [mds_pkg::DATA_W-1:0]   pwdata,
    output logic [mds_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output mds_pkg::t_cfg                o_cfg
);
    import mds_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_duty  <= MAX_DUTY_RST;
            r_cfg.dead_zone <= DEAD_ZONE_RST;
            r_cfg.min_duty  <= MIN_DUTY_RST;
            r_cfg.slew_step <= SLEW_STEP_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAX_DUTY:  r_cfg.max_duty  <= pwdata[DUTY_W-1:0];
                REG_DEAD_ZONE: r_cfg.dead_zone <= pwdata[DUTY_W-1:0];
                REG_MIN_DUTY:  r_cfg.min_duty  <= pwdata[DUTY_W-1:0];
                REG_SLEW_STEP: r_cfg.slew_step <= pwdata[SLEW_W-1:0];
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (reg_idx)
            REG_MAX_DUTY:  prdata = DATA_W'(r_cfg.max_duty);
            REG_DEAD_ZONE: prdata = DATA_W'(r_cfg.dead_zone);
            REG_MIN_DUTY:  prdata = DATA_W'(r_cfg.min_duty);
            REG_SLEW_STEP: prdata = DATA_W'(r_cfg.slew_step);
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* design/mds_shaper.sv */
// ----------------------------------------------------------------------------
// mds_shaper: combinational speed shaping for one command
// Clamp, dead zone, minimum duty, slew limit against the previous output,
// then enable and phase compare values.
// ----------------------------------------------------------------------------
module mds_shaper (
    input  mds_pkg::t_cfg                      i_cfg,
    input  logic signed [mds_pkg::CMD_W-1:0]   i_cmd,
    input  logic signed [mds_pkg::SPEED_W-1:0] i_prev,
    output mds_pkg::t_shaped                   o_res
);
    import mds_pkg::*;

    localparam int unsigned WC = CMD_W + 1;  // clamp width
    localparam int unsigned WS = 13;         // shaping width, holds +-4095

    logic signed [WC-1:0] cmd_x, mx_c, mx_c_neg;
    logic signed [WC-1:0] clamped_c;
    logic signed [WS-1:0] clamped, dz, mn, sl, prev;
    logic signed [WS-1:0] zoned, diff, slewed;
    logic [WS-1:0]        mag;

    always_comb begin
        cmd_x    = WC'(i_cmd);
        mx_c     = $signed({{(WC-DUTY_W){1'b0}}, i_cfg.max_duty});
        mx_c_neg = -mx_c;
        dz       = $signed({{(WS-DUTY_W){1'b0}}, i_cfg.dead_zone});
        mn       = $signed({{(WS-DUTY_W){1'b0}}, i_cfg.min_duty});
        sl       = $signed({{(WS-SLEW_W){1'b0}}, i_cfg.slew_step});
        prev     = WS'(i_prev);

        // clamp to plus or minus max duty
        if (cmd_x > mx_c) begin
            clamped_c = mx_c;
        end else if (cmd_x < mx_c_neg) begin
            clamped_c = mx_c_neg;
        end else begin
            clamped_c = cmd_x;
        end
        clamped = clamped_c[WS-1:0];

        // dead zone and minimum duty
        if (clamped > -dz && clamped < dz) begin
            zoned = '0;
        end else if (clamped > 0 && clamped < mn) begin
            zoned = mn;
        end else if (clamped < 0 && clamped > -mn) begin
            zoned = -mn;
        end else begin
            zoned = clamped;
        end

        // slew limit, a stop bypasses it
        diff   = zoned - prev;
        slewed = zoned;
        if (zoned != 0) begin
            if (diff > sl) begin
                slewed = prev + sl;
            end else if (diff < -sl) begin
                slewed = prev - sl;
            end
        end

        // enable magnitude and phase compare
        mag = slewed[WS-1] ? WS'(-slewed) : WS'(slewed);
        o_res.shaped_speed = slewed[SPEED_W-1:0];
        o_res.enable_duty  = mag[DUTY_W-1:0];
        o_res.phase_write  = (slewed != 0);
        o_res.phase_duty   = slewed[WS-1] ? i_cfg.max_duty : '0;
    end

endmodule

/* design/motor_duty_shaper.sv */
// ----------------------------------------------------------------------------
// motor_duty_shaper: per motor speed command shaping for pwm drive
// Takes signed speed commands, applies clamp, dead zone, minimum duty and
// slew limit per motor, and returns enable and phase compare values.
//
//   channel   dir  width  contents
//   s_axis    in   16+1   command word, tuser selects the motor
//   m_axis    out  32+1   shaped result word, tuser is the motor index
//   apb       in   4/32   max_duty, dead_zone, min_duty, slew_step
//
// one word per cycle sustained while results are taken; a word passes the
// input register, the shaping logic and the result register in that order.
// the per motor last output is written as a result is registered, so a
// following word for the same motor sees it without waiting.
// a stalled result holds the input register, which still takes a word
// when the result register drains. reset clears all motor histories.
// words whose motor select is not below NUM_MOTORS are taken and dropped.
// ----------------------------------------------------------------------------
module motor_duty_shaper #(
    parameter int unsigned NUM_MOTORS = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // command stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [15:0]                  s_axis_tdata,  // [15:0] speed_command
    input  logic                         s_axis_tuser,  // [0] motor_select
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [10:0] shaped_speed, [20:11] enable_duty, [30:21] phase_duty,
    // [31] phase_write
    output logic [31:0]                  m_axis_tdata,
    output logic                         m_axis_tuser,  // [0] motor_index
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mds_pkg::ADDR_W-1:0]   paddr,
    input  logic [mds_pkg::DATA_W-1:0]   pwdata,
    output logic [mds_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import mds_pkg::*;

    localparam int unsigned IDX_W   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam bit          SEL1_OK = (NUM_MOTORS > 1);

    t_cfg                      cfg;
    t_shaped                   shaped;

    logic                      r_in_valid;
    logic                      r_in_sel;
    logic signed [CMD_W-1:0]   r_in_cmd;
    logic                      r_out_valid;
    logic                      r_out_sel;
    t_shaped                   r_out;
    logic signed [SPEED_W-1:0] r_last [NUM_MOTORS];

    logic                      out_free;
    logic                      in_take;
    logic                      in_range;
    logic                      advance;
    logic [IDX_W-1:0]          in_idx;

    // configuration registers
    mds_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // handshake
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign in_range      = (s_axis_tuser == 1'b0) || SEL1_OK;
    assign in_idx        = IDX_W'(r_in_sel);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= in_take && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_sel <= s_axis_tuser;
            r_in_cmd <= s_axis_tdata;
        end
    end

    // shaping logic
    mds_shaper u_shaper (
        .i_cfg  (cfg),
        .i_cmd  (r_in_cmd),
        .i_prev (r_last[in_idx]),
        .o_res  (shaped)
    );

    // per motor history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < NUM_MOTORS; m++) begin
                r_last[m] <= '0;
            end
        end else if (advance) begin
            r_last[in_idx] <= shaped.shaped_speed;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_sel <= r_in_sel;
            r_out     <= shaped;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_sel;
    assign m_axis_tdata  = {r_out.phase_write, r_out.phase_duty,
                            r_out.enable_duty, r_out.shaped_speed};

endmodule
